>>> hw/rtl/char_lcd_nibble_write_sequencer_assert.svh
// assertion macros used by the lcd sequencer port checker
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CLCD_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CLCD_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/clcd_pkg.sv
// types and constants of the character lcd write sequencer
package clcd_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [3:0] NIB_WAKE   = 4'h3;
  localparam logic [3:0] NIB_FOUR   = 4'h2;
  localparam logic [7:0] CLEAR_CODE = 8'h01;

  localparam logic [15:0] RST_ENABLE_HIGH = 16'd5;
  localparam logic [15:0] RST_ENABLE_LOW  = 16'd50;
  localparam logic [15:0] RST_CLEAR_WAIT  = 16'd2000;
  localparam logic [15:0] RST_POWER_UP    = 16'd5000;
  localparam logic [7:0]  RST_FUNC_SET    = 8'h2C;
  localparam logic [7:0]  RST_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0]  RST_ENTRY_MODE  = 8'h06;
  localparam logic [7:0]  RST_HOME_ADDR   = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_HIGH = 8'd0,
    REG_ENABLE_LOW  = 8'd1,
    REG_CLEAR_WAIT  = 8'd2,
    REG_POWER_UP    = 8'd3,
    REG_FUNC_SET    = 8'd4,
    REG_DISPLAY_ON  = 8'd5,
    REG_ENTRY_MODE  = 8'd6,
    REG_HOME_ADDR   = 8'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_POWER        = 4'd0,
    PH_WAKE1        = 4'd1,
    PH_WAKE2        = 4'd2,
    PH_WAKE3        = 4'd3,
    PH_FOUR         = 4'd4,
    PH_FUNC         = 4'd5,
    PH_DISP         = 4'd6,
    PH_ENTRY        = 4'd7,
    PH_CLEAR        = 4'd8,
    PH_HOME         = 4'd9,
    PH_USER         = 4'd10,
    PH_INIT_CLRWAIT = 4'd11,
    PH_USER_CLRWAIT = 4'd12,
    PH_IDLE         = 4'd13
  } phase_t;

  typedef struct packed {
    logic [15:0] enable_high_ticks;
    logic [15:0] enable_low_ticks;
    logic [15:0] clear_wait_ticks;
    logic [15:0] power_up_ticks;
    logic [7:0]  function_set_code;
    logic [7:0]  display_on_code;
    logic [7:0]  entry_mode_code;
    logic [7:0]  home_address_code;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic       reg_select;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       enable_pin;
    logic       select_pin;
    logic [3:0] data_pins;
    logic       busy_res;
    logic       dropped;
  } result_t;

endpackage

>>> hw/rtl/clcd_ifs.sv
// channel interfaces: input items, result items, register writes
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       reg_select;
  logic [7:0] data_byte;
  modport source (output valid, cmd, reg_select, data_byte, input ready);
  modport sink (input valid, cmd, reg_select, data_byte, output ready);
endinterface

interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic       enable_pin;
  logic       select_pin;
  logic [3:0] data_pins;
  logic       busy_res;
  logic       dropped;
  modport source (output valid, enable_pin, select_pin, data_pins, busy_res, dropped,
                  input ready);
  modport sink (input valid, enable_pin, select_pin, data_pins, busy_res, dropped,
                output ready);
endinterface

interface clcd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [clcd_pkg::CFG_IDX_W-1:0]  index;
  logic [clcd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/clcd_cfg_regs.sv
// configuration register bank with reset values
module clcd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [clcd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0] wr_data,
  output clcd_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_high_ticks <= clcd_pkg::RST_ENABLE_HIGH;
      cfg.enable_low_ticks  <= clcd_pkg::RST_ENABLE_LOW;
      cfg.clear_wait_ticks  <= clcd_pkg::RST_CLEAR_WAIT;
      cfg.power_up_ticks    <= clcd_pkg::RST_POWER_UP;
      cfg.function_set_code <= clcd_pkg::RST_FUNC_SET;
      cfg.display_on_code   <= clcd_pkg::RST_DISPLAY_ON;
      cfg.entry_mode_code   <= clcd_pkg::RST_ENTRY_MODE;
      cfg.home_address_code <= clcd_pkg::RST_HOME_ADDR;
    end else if (wr_en) begin
      unique case (wr_index)
        clcd_pkg::REG_ENABLE_HIGH: cfg.enable_high_ticks <= wr_data;
        clcd_pkg::REG_ENABLE_LOW:  cfg.enable_low_ticks  <= wr_data;
        clcd_pkg::REG_CLEAR_WAIT:  cfg.clear_wait_ticks  <= wr_data;
        clcd_pkg::REG_POWER_UP:    cfg.power_up_ticks    <= wr_data;
        clcd_pkg::REG_FUNC_SET:    cfg.function_set_code <= wr_data[7:0];
        clcd_pkg::REG_DISPLAY_ON:  cfg.display_on_code   <= wr_data[7:0];
        clcd_pkg::REG_ENTRY_MODE:  cfg.entry_mode_code   <= wr_data[7:0];
        clcd_pkg::REG_HOME_ADDR:   cfg.home_address_code <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/clcd_seq_core.sv
// phase sequencer, countdown and pin state, one update per accepted item
module clcd_seq_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  clcd_pkg::cfg_t      cfg,
  input  logic                accept,
  input  clcd_pkg::item_t     item,
  output clcd_pkg::result_t   res
);

  localparam int LW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [LW-1:0] TMAX = LW'({TIMER_BITS{1'b1}});

  // saturate a 16-bit setting to the timer width
  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] v);
    logic [LW-1:0] ext;
    ext = LW'(v);
    return (ext > TMAX) ? TIMER_BITS'(TMAX) : TIMER_BITS'(ext);
  endfunction

  clcd_pkg::phase_t      phase, phase_next;
  logic [TIMER_BITS-1:0] countdown, countdown_next;
  logic [7:0]            held_byte, held_byte_next;
  logic                  held_select, held_select_next;
  logic                  second_nibble, second_nibble_next;
  logic                  enable_level, enable_level_next;
  logic [3:0]            nibble_out, nibble_out_next;

  logic                  do_start, do_pulse, do_clrwait, drop;
  clcd_pkg::phase_t      st_phase, cw_phase;
  logic [7:0]            st_byte;
  logic [3:0]            pulse_nib;
  logic [TIMER_BITS-1:0] cd_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= clcd_pkg::PH_POWER;
      countdown     <= timer_load(clcd_pkg::RST_POWER_UP);
      held_byte     <= '0;
      held_select   <= 1'b0;
      second_nibble <= 1'b0;
      enable_level  <= 1'b0;
      nibble_out    <= '0;
    end else begin
      phase         <= phase_next;
      countdown     <= countdown_next;
      held_byte     <= held_byte_next;
      held_select   <= held_select_next;
      second_nibble <= second_nibble_next;
      enable_level  <= enable_level_next;
      nibble_out    <= nibble_out_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    countdown_next     = countdown;
    held_byte_next     = held_byte;
    held_select_next   = held_select;
    second_nibble_next = second_nibble;
    enable_level_next  = enable_level;
    nibble_out_next    = nibble_out;
    do_start   = 1'b0;
    do_pulse   = 1'b0;
    do_clrwait = 1'b0;
    drop       = 1'b0;
    st_phase   = clcd_pkg::PH_IDLE;
    cw_phase   = clcd_pkg::PH_IDLE;
    st_byte    = '0;
    pulse_nib  = '0;
    cd_dec     = (countdown != '0) ? countdown - TIMER_BITS'(1) : '0;

    if (accept) begin
      if (item.cmd) begin
        if (phase != clcd_pkg::PH_IDLE) begin
          drop = 1'b1;
        end else begin
          do_start         = 1'b1;
          st_phase         = clcd_pkg::PH_USER;
          st_byte          = item.data_byte;
          held_select_next = item.reg_select;
        end
      end else if (phase != clcd_pkg::PH_IDLE) begin
        countdown_next = cd_dec;
        if (cd_dec == '0) begin
          if (enable_level) begin
            enable_level_next = 1'b0;
            countdown_next    = timer_load(cfg.enable_low_ticks);
          end else begin
            unique case (phase) inside
              clcd_pkg::PH_POWER: begin
                phase_next = clcd_pkg::PH_WAKE1;
                do_pulse   = 1'b1;
                pulse_nib  = clcd_pkg::NIB_WAKE;
              end
              clcd_pkg::PH_WAKE1: begin
                phase_next = clcd_pkg::PH_WAKE2;
                do_pulse   = 1'b1;
                pulse_nib  = clcd_pkg::NIB_WAKE;
              end
              clcd_pkg::PH_WAKE2: begin
                phase_next = clcd_pkg::PH_WAKE3;
                do_pulse   = 1'b1;
                pulse_nib  = clcd_pkg::NIB_WAKE;
              end
              clcd_pkg::PH_WAKE3: begin
                phase_next = clcd_pkg::PH_FOUR;
                do_pulse   = 1'b1;
                pulse_nib  = clcd_pkg::NIB_FOUR;
              end
              clcd_pkg::PH_FOUR: begin
                do_start         = 1'b1;
                st_phase         = clcd_pkg::PH_FUNC;
                st_byte          = cfg.function_set_code;
                held_select_next = 1'b0;
              end
              clcd_pkg::PH_INIT_CLRWAIT: begin
                do_start         = 1'b1;
                st_phase         = clcd_pkg::PH_HOME;
                st_byte          = cfg.home_address_code;
                held_select_next = 1'b0;
              end
              clcd_pkg::PH_USER_CLRWAIT: phase_next = clcd_pkg::PH_IDLE;
              clcd_pkg::PH_FUNC, clcd_pkg::PH_DISP, clcd_pkg::PH_ENTRY,
              clcd_pkg::PH_CLEAR, clcd_pkg::PH_HOME, clcd_pkg::PH_USER: begin
                if (!second_nibble) begin
                  second_nibble_next = 1'b1;
                  do_pulse           = 1'b1;
                  pulse_nib          = held_byte[3:0];
                end else begin
                  unique case (phase)
                    clcd_pkg::PH_FUNC: begin
                      do_start         = 1'b1;
                      st_phase         = clcd_pkg::PH_DISP;
                      st_byte          = cfg.display_on_code;
                      held_select_next = 1'b0;
                    end
                    clcd_pkg::PH_DISP: begin
                      do_start         = 1'b1;
                      st_phase         = clcd_pkg::PH_ENTRY;
                      st_byte          = cfg.entry_mode_code;
                      held_select_next = 1'b0;
                    end
                    clcd_pkg::PH_ENTRY: begin
                      do_start         = 1'b1;
                      st_phase         = clcd_pkg::PH_CLEAR;
                      st_byte          = clcd_pkg::CLEAR_CODE;
                      held_select_next = 1'b0;
                    end
                    clcd_pkg::PH_CLEAR: begin
                      do_clrwait = 1'b1;
                      cw_phase   = clcd_pkg::PH_INIT_CLRWAIT;
                    end
                    clcd_pkg::PH_HOME: phase_next = clcd_pkg::PH_IDLE;
                    default: begin
                      // end of a user transfer, a clear command adds its wait
                      held_select_next = 1'b0;
                      if (!held_select && held_byte == clcd_pkg::CLEAR_CODE) begin
                        do_clrwait = 1'b1;
                        cw_phase   = clcd_pkg::PH_USER_CLRWAIT;
                      end else begin
                        phase_next = clcd_pkg::PH_IDLE;
                      end
                    end
                  endcase
                end
              end
              default: phase_next = clcd_pkg::PH_IDLE;
            endcase
          end
        end
      end
    end

    if (do_start) begin
      phase_next         = st_phase;
      held_byte_next     = st_byte;
      second_nibble_next = 1'b0;
      do_pulse           = 1'b1;
      pulse_nib          = st_byte[7:4];
    end
    if (do_pulse) begin
      nibble_out_next   = pulse_nib;
      enable_level_next = 1'b1;
      countdown_next    = timer_load(cfg.enable_high_ticks);
    end
    if (do_clrwait) begin
      phase_next     = cw_phase;
      countdown_next = timer_load(cfg.clear_wait_ticks);
    end

    res.enable_pin = enable_level_next;
    res.select_pin = held_select_next;
    res.data_pins  = nibble_out_next;
    res.busy_res   = (phase_next != clcd_pkg::PH_IDLE);
    res.dropped    = drop;
  end

endmodule

>>> hw/rtl/clcd_out_buf.sv
// two-entry result buffer: output register plus skid register
module clcd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  clcd_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output clcd_pkg::result_t out_data
);

  logic              skid_valid;
  clcd_pkg::result_t skid_data;
  logic              take;

  assign push_ready = !skid_valid;
  assign take       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push && !out_valid) begin
      out_data <= push_data;
    end
    if (push && out_valid && !take) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> hw/rtl/char_lcd_nibble_write_sequencer.sv
// top level: 4-bit character lcd write sequencer
// Drives an HD44780-style character LCD over a 4-bit bus. Every input transaction is either
// one microsecond tick (cmd 0) or a byte write (cmd 1) with a register-select bit, and every
// input transaction yields exactly one result transaction that shows the pin levels, the busy
// flag and a dropped flag after that step. After reset the block runs the init sequence on
// ticks (power-up wait, nibble 3 three times, nibble 2, function set, display control, entry
// mode, clear plus clear wait, home address) and reports busy until it ends; writes that come
// in while busy are ignored and flagged as dropped. Bytes go out high nibble first, each with
// an enable pulse of enable_high_ticks high and enable_low_ticks low; a clear command adds
// clear_wait_ticks. Rate: one transaction per clock, sustained while the output channel takes
// results. The whole step is a single combinational update of the phase, countdown and pin
// registers, and its result reaches the output channel through the output buffer registers.
// The two-entry result buffer lets input flow while its skid register is free and stalls it once full.
// Configuration writes are taken every cycle and must only be issued while the block is idle.
module char_lcd_nibble_write_sequencer #(
  parameter int TIMER_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  clcd_in_if.sink    in_ch,
  clcd_out_if.source out_ch,
  clcd_cfg_if.sink   cfg
);

  clcd_pkg::cfg_t    cfg_regs;
  clcd_pkg::item_t   item;
  clcd_pkg::result_t step_res;
  clcd_pkg::result_t out_res;
  logic              in_accept;
  logic              buf_ready;

  // register writes complete every cycle
  assign cfg.ready = 1'b1;

  clcd_cfg_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  assign item.cmd        = in_ch.cmd;
  assign item.reg_select = in_ch.reg_select;
  assign item.data_byte  = in_ch.data_byte;

  // input side stalls only when both buffer entries are taken
  assign in_ch.ready = buf_ready;
  assign in_accept   = in_ch.valid && buf_ready;

  clcd_seq_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .accept (in_accept),
    .item   (item),
    .res    (step_res)
  );

  clcd_out_buf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (in_accept),
    .push_data  (step_res),
    .push_ready (buf_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_res)
  );

  assign out_ch.enable_pin = out_res.enable_pin;
  assign out_ch.select_pin = out_res.select_pin;
  assign out_ch.data_pins  = out_res.data_pins;
  assign out_ch.busy_res   = out_res.busy_res;
  assign out_ch.dropped    = out_res.dropped;

endmodule

>>> hw/rtl/clcd_port_checker.sv
// port-level checker for the lcd sequencer, bound to the top level
`include "char_lcd_nibble_write_sequencer_assert.svh"

module clcd_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       enable_pin,
  input logic       select_pin,
  input logic [3:0] data_pins,
  input logic       busy_res,
  input logic       dropped
);

  // a dropped write never changes phase, so the block is still busy
  `CLCD_ASSERT_IMP(a_drop_busy, clk, rst, out_valid && dropped, busy_res, "dropped while idle")

  // enable only pulses inside a transfer or init
  `CLCD_ASSERT_IMP(a_en_busy, clk, rst, out_valid && enable_pin, busy_res, "enable high while idle")

  // input stalls only behind a pending result
  `CLCD_ASSERT_IMP(a_stall_cause, clk, rst, !in_ready, out_valid, "input stalled with no result")

  // a stalled result holds
  `CLCD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable({enable_pin, select_pin, data_pins, busy_res, dropped}),
    "result changed while stalled")

endmodule

bind char_lcd_nibble_write_sequencer clcd_port_checker u_port_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .enable_pin (out_ch.enable_pin),
  .select_pin (out_ch.select_pin),
  .data_pins  (out_ch.data_pins),
  .busy_res   (out_ch.busy_res),
  .dropped    (out_ch.dropped)
);

>>> bench/tb.sv
// testbench for the 4-bit character lcd write sequencer: directed table, then random traffic
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // operation and select codes of one input transaction
  localparam logic TICK     = 1'b0;
  localparam logic WRITE    = 1'b1;
  localparam logic SEL_CMD  = 1'b0;
  localparam logic SEL_DATA = 1'b1;

  // index past the last register, must leave every setting alone
  localparam logic [clcd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd200;

  // generous cycle budget for a correct run with the longest gaps
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          PLAN_LEN    = 17;

  logic clk = 1'b0;
  logic rst;

  always #1 clk = ~clk;

  clcd_in_if  in_ch ();
  clcd_out_if out_ch ();
  clcd_cfg_if cfg_ch ();

  char_lcd_nibble_write_sequencer uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // predictor state: one copy of the sequencer, stepped once per accepted item
  // ---------------------------------------------------------------------------
  clcd_pkg::cfg_t   lcd_regs;
  clcd_pkg::phase_t lcd_phase;
  logic [15:0]      lcd_count;
  logic [7:0]       lcd_byte;
  logic             lcd_sel;
  logic             low_half;    // set once the high nibble of the held byte went out
  logic             en_level;
  logic [3:0]       bus_nib;

  clcd_pkg::result_t pins_due[$];  // pin levels still owed by the output channel
  int                pin_mismatches = 0;
  int unsigned       cycle_count    = 0;
  bit                no_idle        = 1'b0;  // both sides run flat out while set
  int                hold_len       = 0;     // one-shot long stall request for the receiver

  initial begin
    lcd_regs.enable_high_ticks = clcd_pkg::RST_ENABLE_HIGH;
    lcd_regs.enable_low_ticks  = clcd_pkg::RST_ENABLE_LOW;
    lcd_regs.clear_wait_ticks  = clcd_pkg::RST_CLEAR_WAIT;
    lcd_regs.power_up_ticks    = clcd_pkg::RST_POWER_UP;
    lcd_regs.function_set_code = clcd_pkg::RST_FUNC_SET;
    lcd_regs.display_on_code   = clcd_pkg::RST_DISPLAY_ON;
    lcd_regs.entry_mode_code   = clcd_pkg::RST_ENTRY_MODE;
    lcd_regs.home_address_code = clcd_pkg::RST_HOME_ADDR;
    lcd_phase = clcd_pkg::PH_POWER;
    lcd_count = clcd_pkg::RST_POWER_UP;
    lcd_byte  = '0;
    lcd_sel   = 1'b0;
    low_half  = 1'b0;
    en_level  = 1'b0;
    bus_nib   = '0;
  end

  // raise enable with a nibble on the bus and load the high time
  function automatic void pulse_nibble(input logic [3:0] nib);
    bus_nib   = nib;
    en_level  = 1'b1;
    lcd_count = lcd_regs.enable_high_ticks;
  endfunction

  // latch a byte and put its high nibble out first
  function automatic void load_byte(input clcd_pkg::phase_t next, input logic [7:0] b,
                                    input logic sel);
    lcd_phase = next;
    lcd_byte  = b;
    lcd_sel   = sel;
    low_half  = 1'b0;
    pulse_nibble(b[7:4]);
  endfunction

  function automatic void start_clear_wait(input clcd_pkg::phase_t next);
    lcd_phase = next;
    lcd_count = lcd_regs.clear_wait_ticks;
  endfunction

  // what follows once a pulse and its low time are both over
  function automatic void next_phase();
    case (lcd_phase)
      clcd_pkg::PH_POWER: begin
        lcd_phase = clcd_pkg::PH_WAKE1;
        pulse_nibble(clcd_pkg::NIB_WAKE);
      end
      clcd_pkg::PH_WAKE1: begin
        lcd_phase = clcd_pkg::PH_WAKE2;
        pulse_nibble(clcd_pkg::NIB_WAKE);
      end
      clcd_pkg::PH_WAKE2: begin
        lcd_phase = clcd_pkg::PH_WAKE3;
        pulse_nibble(clcd_pkg::NIB_WAKE);
      end
      clcd_pkg::PH_WAKE3: begin
        lcd_phase = clcd_pkg::PH_FOUR;
        pulse_nibble(clcd_pkg::NIB_FOUR);
      end
      clcd_pkg::PH_FOUR:
        load_byte(clcd_pkg::PH_FUNC, lcd_regs.function_set_code, SEL_CMD);
      clcd_pkg::PH_INIT_CLRWAIT:
        load_byte(clcd_pkg::PH_HOME, lcd_regs.home_address_code, SEL_CMD);
      clcd_pkg::PH_USER_CLRWAIT: lcd_phase = clcd_pkg::PH_IDLE;
      clcd_pkg::PH_FUNC, clcd_pkg::PH_DISP, clcd_pkg::PH_ENTRY, clcd_pkg::PH_CLEAR,
      clcd_pkg::PH_HOME, clcd_pkg::PH_USER: begin
        if (!low_half) begin
          low_half = 1'b1;
          pulse_nibble(lcd_byte[3:0]);
        end else begin
          case (lcd_phase)
            clcd_pkg::PH_FUNC:
              load_byte(clcd_pkg::PH_DISP, lcd_regs.display_on_code, SEL_CMD);
            clcd_pkg::PH_DISP:
              load_byte(clcd_pkg::PH_ENTRY, lcd_regs.entry_mode_code, SEL_CMD);
            clcd_pkg::PH_ENTRY:
              load_byte(clcd_pkg::PH_CLEAR, clcd_pkg::CLEAR_CODE, SEL_CMD);
            clcd_pkg::PH_CLEAR: start_clear_wait(clcd_pkg::PH_INIT_CLRWAIT);
            clcd_pkg::PH_HOME:  lcd_phase = clcd_pkg::PH_IDLE;
            default: begin
              // end of a user byte: select drops, a clear command earns the long wait
              if (lcd_sel == SEL_CMD && lcd_byte == clcd_pkg::CLEAR_CODE) begin
                lcd_sel = SEL_CMD;
                start_clear_wait(clcd_pkg::PH_USER_CLRWAIT);
              end else begin
                lcd_sel   = SEL_CMD;
                lcd_phase = clcd_pkg::PH_IDLE;
              end
            end
          endcase
        end
      end
      default: lcd_phase = clcd_pkg::PH_IDLE;
    endcase
  endfunction

  // one step of the sequencer; returns the pin levels after it
  function automatic clcd_pkg::result_t predict_pins(input clcd_pkg::item_t it);
    clcd_pkg::result_t r;
    r.dropped = 1'b0;
    if (it.cmd == WRITE) begin
      if (lcd_phase != clcd_pkg::PH_IDLE) r.dropped = 1'b1;
      else load_byte(clcd_pkg::PH_USER, it.data_byte, it.reg_select);
    end else if (lcd_phase != clcd_pkg::PH_IDLE) begin
      // a zero load still costs one tick: the count only expires on a tick
      if (lcd_count != 0) lcd_count = lcd_count - 16'd1;
      if (lcd_count == 0) begin
        if (en_level) begin
          en_level  = 1'b0;
          lcd_count = lcd_regs.enable_low_ticks;
        end else begin
          next_phase();
        end
      end
    end
    r.enable_pin = en_level;
    r.select_pin = lcd_sel;
    r.data_pins  = bus_nib;
    r.busy_res   = (lcd_phase != clcd_pkg::PH_IDLE);
    return r;
  endfunction

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one item; valid stays up when the next gap draws zero
  task automatic send_item(input clcd_pkg::item_t it, input logic typed,
                           input clcd_pkg::result_t want);
    clcd_pkg::result_t calc;
    int                gap;
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= it.cmd;
    in_ch.reg_select <= it.reg_select;
    in_ch.data_byte  <= it.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    calc = predict_pins(it);
    pins_due.push_back(typed ? want : calc);
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write, only issued with nothing owed on the output channel
  task automatic write_reg(input logic [clcd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      clcd_pkg::REG_ENABLE_HIGH: lcd_regs.enable_high_ticks = val;
      clcd_pkg::REG_ENABLE_LOW:  lcd_regs.enable_low_ticks  = val;
      clcd_pkg::REG_CLEAR_WAIT:  lcd_regs.clear_wait_ticks  = val;
      clcd_pkg::REG_POWER_UP:    lcd_regs.power_up_ticks    = val;
      clcd_pkg::REG_FUNC_SET:    lcd_regs.function_set_code = val[7:0];
      clcd_pkg::REG_DISPLAY_ON:  lcd_regs.display_on_code   = val[7:0];
      clcd_pkg::REG_ENTRY_MODE:  lcd_regs.entry_mode_code   = val[7:0];
      clcd_pkg::REG_HOME_ADDR:   lcd_regs.home_address_code = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_timing(input logic [15:0] hi, input logic [15:0] lo,
                              input logic [15:0] clr);
    write_reg(clcd_pkg::REG_ENABLE_HIGH, hi);
    write_reg(clcd_pkg::REG_ENABLE_LOW, lo);
    write_reg(clcd_pkg::REG_CLEAR_WAIT, clr);
  endtask

  // ticks until the sequencer goes idle, with the odd write that must be dropped
  task automatic tick_until_idle();
    clcd_pkg::item_t it;
    while (lcd_phase != clcd_pkg::PH_IDLE) begin
      it.cmd        = ($urandom_range(0, 15) == 0) ? WRITE : TICK;
      it.reg_select = 1'($urandom_range(0, 1));
      it.data_byte  = 8'($urandom_range(0, 255));
      send_item(it, 1'b0, '0);
    end
  endtask

  // stop offering and let every owed result come back
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed traffic: a write when idle, then ticks with stray writes
  task automatic random_traffic(input int count);
    clcd_pkg::item_t it;
    int              taken;
    bit              counts;
    taken = 0;
    while (taken < count) begin
      if ($urandom_range(0, 149) == 0) no_idle = !no_idle;
      it.reg_select = 1'($urandom_range(0, 1));
      it.data_byte  = 8'($urandom_range(0, 255));
      if (lcd_phase == clcd_pkg::PH_IDLE) begin
        it.cmd = ($urandom_range(0, 9) != 0) ? WRITE : TICK;
        if (it.cmd == WRITE && $urandom_range(0, 7) == 0) begin
          it.reg_select = SEL_CMD;
          it.data_byte  = clcd_pkg::CLEAR_CODE;
        end
        counts = (it.cmd == WRITE);
      end else begin
        it.cmd = ($urandom_range(0, 9) == 0) ? WRITE : TICK;
        counts = (it.cmd == TICK);
      end
      if (counts) taken++;
      send_item(it, 1'b0, '0);
    end
    no_idle = 1'b0;
    tick_until_idle();
  endtask

  // ---------------------------------------------------------------------------
  // directed table; typed results are {enable, select, pins, busy, dropped}
  // rows with typed=0 are checked against the predictor
  // ---------------------------------------------------------------------------
  typedef struct packed {
    clcd_pkg::item_t   it;
    logic              typed;
    logic              run_out;  // tick until idle after this row
    clcd_pkg::result_t want;
  } plan_row_t;

  plan_row_t directed_plan [PLAN_LEN] = '{
    // power-up wait: tick fields ignored, writes dropped, pins at zero
    {{TICK,  SEL_DATA, 8'hFF}, 1'b1, 1'b0, {1'b0, 1'b0, 4'h0, 1'b1, 1'b0}},
    {{WRITE, SEL_CMD,  8'h00}, 1'b1, 1'b0, {1'b0, 1'b0, 4'h0, 1'b1, 1'b1}},
    {{WRITE, SEL_DATA, 8'hFF}, 1'b1, 1'b0, {1'b0, 1'b0, 4'h0, 1'b1, 1'b1}},
    // this one runs the whole init sequence afterwards
    {{TICK,  SEL_CMD,  8'h00}, 1'b1, 1'b1, {1'b0, 1'b0, 4'h0, 1'b1, 1'b0}},
    // idle tick: pins keep the low nibble of the home address
    {{TICK,  SEL_DATA, 8'hAA}, 1'b0, 1'b0, 8'h00},
    {{WRITE, SEL_DATA, 8'hFF}, 1'b1, 1'b1, {1'b1, 1'b1, 4'hF, 1'b1, 1'b0}},
    // select back to zero after a data transfer, bus holds the last nibble
    {{TICK,  SEL_DATA, 8'h55}, 1'b1, 1'b0, {1'b0, 1'b0, 4'hF, 1'b0, 1'b0}},
    {{WRITE, SEL_DATA, 8'h00}, 1'b1, 1'b1, {1'b1, 1'b1, 4'h0, 1'b1, 1'b0}},
    // user clear with a zero clear wait
    {{WRITE, SEL_CMD,  clcd_pkg::CLEAR_CODE}, 1'b1, 1'b0, {1'b1, 1'b0, 4'h0, 1'b1, 1'b0}},
    {{TICK,  SEL_CMD,  8'h00}, 1'b0, 1'b1, 8'h00},
    // second write lands while the first is still on the bus
    {{WRITE, SEL_DATA, 8'h5A}, 1'b1, 1'b0, {1'b1, 1'b1, 4'h5, 1'b1, 1'b0}},
    {{WRITE, SEL_CMD,  8'h3C}, 1'b1, 1'b0, {1'b1, 1'b1, 4'h5, 1'b1, 1'b1}},
    {{TICK,  SEL_DATA, 8'hFF}, 1'b0, 1'b1, 8'h00},
    // 0x01 as character data is not a clear
    {{WRITE, SEL_DATA, clcd_pkg::CLEAR_CODE}, 1'b1, 1'b1, {1'b1, 1'b1, 4'h0, 1'b1, 1'b0}},
    {{WRITE, SEL_CMD,  8'h80}, 1'b1, 1'b1, {1'b1, 1'b0, 4'h8, 1'b1, 1'b0}},
    {{TICK,  SEL_CMD,  8'h00}, 1'b1, 1'b0, {1'b0, 1'b0, 4'h0, 1'b0, 1'b0}},
    {{WRITE, SEL_CMD,  8'hFF}, 1'b1, 1'b1, {1'b1, 1'b0, 4'hF, 1'b1, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= TICK;
    in_ch.reg_select <= SEL_CMD;
    in_ch.data_byte  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    rst              <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // before any tick: fastest pulses, zero clear wait, odd init codes;
    // the power-up count is loaded only at reset, so its register has no effect here
    write_timing(16'd1, 16'd1, 16'd0);
    write_reg(clcd_pkg::REG_POWER_UP, 16'd0);
    write_reg(clcd_pkg::REG_FUNC_SET, 16'h0000);
    write_reg(clcd_pkg::REG_DISPLAY_ON, 16'h00FF);
    write_reg(clcd_pkg::REG_ENTRY_MODE, 16'($urandom_range(0, 255)));
    write_reg(clcd_pkg::REG_HOME_ADDR, 16'($urandom_range(0, 255)));
    write_reg(REG_UNUSED, 16'hFFFF);

    for (k = 0; k < PLAN_LEN; k++) begin
      send_item(directed_plan[k].it, directed_plan[k].typed, directed_plan[k].want);
      if (directed_plan[k].run_out) tick_until_idle();
    end

    // minimum timings
    random_traffic(450);
    quiesce();

    // short random timings, receiver stalls long at the start to back up the input
    write_timing(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                 16'($urandom_range(0, 30)));
    hold_len = 400;
    random_traffic(450);
    quiesce();

    // long timings and extreme codes: one clear command, run flat out
    no_idle = 1'b1;
    write_timing(16'd100, 16'd100, 16'd300);
    write_reg(clcd_pkg::REG_POWER_UP, 16'hFFFF);
    write_reg(clcd_pkg::REG_FUNC_SET, 16'h00FF);
    write_reg(clcd_pkg::REG_DISPLAY_ON, 16'h0000);
    write_reg(clcd_pkg::REG_ENTRY_MODE, 16'h00FF);
    write_reg(clcd_pkg::REG_HOME_ADDR, 16'h00FF);
    send_item({WRITE, SEL_CMD, clcd_pkg::CLEAR_CODE}, 1'b1, {1'b1, 1'b0, 4'h0, 1'b1, 1'b0});
    tick_until_idle();
    quiesce();
    no_idle = 1'b0;

    // mid-range random timings
    write_timing(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                 16'($urandom_range(0, 100)));
    write_reg(clcd_pkg::REG_POWER_UP, 16'($urandom_range(0, 65535)));
    random_traffic(450);
    quiesce();

    // back to the power-on timings
    write_timing(clcd_pkg::RST_ENABLE_HIGH, clcd_pkg::RST_ENABLE_LOW,
                 clcd_pkg::RST_CLEAR_WAIT);
    random_traffic(450);
    quiesce();

    repeat (10) @(posedge clk);
    if (pin_mismatches == 0 && pins_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: random stall per transaction, one long hold on request
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = idle_cycles();
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // compare each result transaction with the oldest owed pin levels
  always @(posedge clk) begin : pin_check
    clcd_pkg::result_t got;
    clcd_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.enable_pin, out_ch.select_pin, out_ch.data_pins,
             out_ch.busy_res, out_ch.dropped};
      if (pins_due.size() == 0) begin
        pin_mismatches++;
        if (pin_mismatches <= 10)
          $display("unexpected result: en=%0b sel=%0b d=%h busy=%0b drop=%0b",
                   got.enable_pin, got.select_pin, got.data_pins, got.busy_res,
                   got.dropped);
      end else begin
        want = pins_due.pop_front();
        if (got.enable_pin !== want.enable_pin || got.select_pin !== want.select_pin ||
            got.data_pins !== want.data_pins || got.busy_res !== want.busy_res ||
            got.dropped !== want.dropped) begin
          pin_mismatches++;
          if (pin_mismatches <= 10)
            $display("pin mismatch: want en=%0b sel=%0b d=%h busy=%0b drop=%0b, got en=%0b sel=%0b d=%h busy=%0b drop=%0b",
                     want.enable_pin, want.select_pin, want.data_pins, want.busy_res,
                     want.dropped, got.enable_pin, got.select_pin, got.data_pins,
                     got.busy_res, got.dropped);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
